// ===== design/ledcc_pkg.sv =====
// Shared constants and types for the LED pixel color correction block.
package ledcc_pkg;

    localparam int GAIN_FRAC_BITS_DEFAULT = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_ENABLES   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_GAIN        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_GAIN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_GAIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_GAIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SATURATION_GAIN = 3'd5;

    localparam int EN_MASTER     = 0;
    localparam int EN_WHITE      = 1;
    localparam int EN_GAMMA      = 2;
    localparam int EN_BRIGHTNESS = 3;
    localparam int EN_SATURATION = 4;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    localparam int DIV_W         = 11;
    localparam int DIV_STEPS     = 17;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = FIFO_AW + 1;

    typedef logic [2:0][7:0] rgb_t;

endpackage

// ===== design/ledcc_div.sv =====
// Pipelined restoring divider, two quotient bits per stage.
module ledcc_div (
    input  logic                            clk,
    input  logic [ledcc_pkg::DIV_W-1:0]     rem_in,
    input  logic [ledcc_pkg::DIV_W-1:0]     div_in,
    input  logic [ledcc_pkg::DIV_STEPS-1:0] bits_in,
    output logic [ledcc_pkg::DIV_STEPS-1:0] quot
);

    typedef struct packed {
        logic [ledcc_pkg::DIV_W-1:0]     rem;
        logic [ledcc_pkg::DIV_W-1:0]     dvs;
        logic [ledcc_pkg::DIV_STEPS-1:0] bits;
        logic [ledcc_pkg::DIV_STEPS-1:0] quot;
    } div_stage_t;

    div_stage_t stage_reg  [ledcc_pkg::DIV_STAGES];
    div_stage_t stage_next [ledcc_pkg::DIV_STAGES];
    div_stage_t stage_src  [ledcc_pkg::DIV_STAGES];

    always_comb
    begin
        div_stage_t cur;
        logic [ledcc_pkg::DIV_W:0] trial;
        logic qb;
        stage_src[0].rem  = rem_in;
        stage_src[0].dvs  = div_in;
        stage_src[0].bits = bits_in;
        stage_src[0].quot = '0;
        for (int s = 1; s < ledcc_pkg::DIV_STAGES; s++)
        begin
            stage_src[s] = stage_reg[s-1];
        end
        for (int s = 0; s < ledcc_pkg::DIV_STAGES; s++)
        begin
            cur = stage_src[s];
            for (int j = 0; j < ledcc_pkg::DIV_PER_STAGE; j++)
            begin
                if (s * ledcc_pkg::DIV_PER_STAGE + j < ledcc_pkg::DIV_STEPS)
                begin
                    trial = {cur.rem, cur.bits[ledcc_pkg::DIV_STEPS-1]};
                    if (trial >= {1'b0, cur.dvs})
                    begin
                        trial = trial - {1'b0, cur.dvs};
                        qb = 1'b1;
                    end
                    else
                    begin
                        qb = 1'b0;
                    end
                    cur.rem  = trial[ledcc_pkg::DIV_W-1:0];
                    cur.quot = {cur.quot[ledcc_pkg::DIV_STEPS-2:0], qb};
                    cur.bits = {cur.bits[ledcc_pkg::DIV_STEPS-2:0], 1'b0};
                end
            end
            stage_next[s] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ledcc_pkg::DIV_STAGES; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    assign quot = stage_reg[ledcc_pkg::DIV_STAGES-1].quot;

endmodule

// ===== design/led_pixel_color_correction.sv =====
// Top level of the LED pixel color correction pipeline.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------------
//  input   | in_valid / in_stall  | req_type, red_in, green_in, blue_in,
//          |                      | table_index, table_value
//  output  | out_valid / out_stall| red_out, green_out, blue_out
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction is taken per cycle while in_stall is low, pixel or table write;
// a pixel result passes through the nine stage divider pipeline of the saturation
// path, and the gamma memories take one write per cycle.
// Reset clears the pipeline, the result queue and the registers; the gamma table
// holds no defined data until loaded. Results queue in a 32 entry buffer and the
// input stalls only while 32 pixels are outstanding.
module led_pixel_color_correction #(
    parameter int GAIN_FRAC_BITS = ledcc_pkg::GAIN_FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    input  logic [7:0]                        table_index,
    input  logic [7:0]                        table_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        red_out,
    output logic [7:0]                        green_out,
    output logic [7:0]                        blue_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ledcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ledcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [25:0] GAIN_HALF = 26'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [16:0] UNITY     = 17'(1) << GAIN_FRAC_BITS;
    localparam int ST = ledcc_pkg::DIV_STAGES;
    localparam int QW = ledcc_pkg::DIV_STEPS;

    typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

    typedef struct packed {
        logic              sat_on;
        ledcc_pkg::rgb_t   c;
        logic              dnz;
        logic [8:0]        sm;
        logic [16:0]       l;
    } side_t;

    function automatic logic [7:0] gain_apply(input logic [7:0] c, input logic [16:0] g);
        logic [25:0] prod;
        logic [25:0] sh;
        prod = 26'(c) * 26'(g) + GAIN_HALF;
        sh = prod >> GAIN_FRAC_BITS;
        return (sh > 26'd255) ? 8'hFF : sh[7:0];
    endfunction

    // Configuration registers.
    logic [4:0]  enables_reg;
    logic [16:0] red_gain_reg, green_gain_reg, blue_gain_reg;
    logic [16:0] bright_gain_reg, sat_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg     <= '0;
            red_gain_reg    <= UNITY;
            green_gain_reg  <= UNITY;
            blue_gain_reg   <= UNITY;
            bright_gain_reg <= UNITY;
            sat_gain_reg    <= UNITY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ledcc_pkg::REG_STAGE_ENABLES:   enables_reg     <= cfg_data[4:0];
                ledcc_pkg::REG_RED_GAIN:        red_gain_reg    <= {1'b0, cfg_data};
                ledcc_pkg::REG_GREEN_GAIN:      green_gain_reg  <= {1'b0, cfg_data};
                ledcc_pkg::REG_BLUE_GAIN:       blue_gain_reg   <= {1'b0, cfg_data};
                ledcc_pkg::REG_BRIGHTNESS_GAIN: bright_gain_reg <= {1'b0, cfg_data};
                ledcc_pkg::REG_SATURATION_GAIN: sat_gain_reg    <= {1'b0, cfg_data};
                default: ;
            endcase
        end
    end

    logic white_on, gamma_on, bright_on, sat_on;
    logic [2:0][16:0] white_gain;

    assign white_on  = enables_reg[ledcc_pkg::EN_MASTER] && enables_reg[ledcc_pkg::EN_WHITE];
    assign gamma_on  = enables_reg[ledcc_pkg::EN_MASTER] && enables_reg[ledcc_pkg::EN_GAMMA];
    assign bright_on = enables_reg[ledcc_pkg::EN_MASTER] &&
                       enables_reg[ledcc_pkg::EN_BRIGHTNESS] && (bright_gain_reg != UNITY);
    assign sat_on    = enables_reg[ledcc_pkg::EN_MASTER] &&
                       enables_reg[ledcc_pkg::EN_SATURATION] && (sat_gain_reg != UNITY);
    assign white_gain = {blue_gain_reg, green_gain_reg, red_gain_reg};

    // Handshake and credit accounting.
    logic in_accept, in_pixel, out_pop;
    logic [ledcc_pkg::CREDIT_W-1:0] credit_reg, credit_next;
    logic [ledcc_pkg::CREDIT_W-1:0] fill_reg, fill_next;
    logic [ledcc_pkg::FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;

    assign in_stall  = (credit_reg == ledcc_pkg::CREDIT_W'(ledcc_pkg::FIFO_DEPTH));
    assign in_accept = in_valid && !in_stall;
    assign in_pixel  = in_accept && (req_type == ledcc_pkg::REQ_PIXEL);
    assign out_valid = (fill_reg != '0);
    assign out_pop   = out_valid && !out_stall;

    // Pipeline registers.
    logic            a_valid_reg, a_req_reg;
    ledcc_pkg::rgb_t a_c_reg;
    logic [7:0]      a_idx_reg, a_val_reg;
    logic            b_valid_reg, b_req_reg;
    ledcc_pkg::rgb_t b_c_reg;
    logic [7:0]      b_idx_reg, b_val_reg;
    logic            c_valid_reg;
    ledcc_pkg::rgb_t c_c_reg, c_gq_reg;
    logic            d_valid_reg;
    ledcc_pkg::rgb_t d_c_reg;
    logic            e_valid_reg, e_sat_on_reg;
    ledcc_pkg::rgb_t e_c_reg;
    logic [7:0]      e_dl_reg;
    logic [8:0]      e_sm_reg, e_den_reg;
    logic [10:0]     e_d6_reg, e_num_reg;
    logic [ST-1:0]   side_valid_reg;
    side_t           side_reg [ST];
    logic            f_valid_reg;
    side_t           f_side_reg;
    logic [33:0]     f_prod_reg;
    logic [15:0]     f_h_reg;
    logic            g_valid_reg, g_gray_reg;
    side_t           g_side_reg;
    logic [16:0]     g_ls_reg, g_sn_reg;
    logic [15:0]     g_h_reg;
    logic            hh_valid_reg, hh_gray_reg;
    side_t           hh_side_reg;
    logic [17:0]     hh_p_reg, hh_q_reg;
    logic [2:0][16:0] hh_fac_reg;
    seg_t            hh_mode_reg [3];
    logic            i_valid_reg, i_gray_reg;
    side_t           i_side_reg;
    logic [17:0]     i_p_reg, i_q_reg;
    logic [2:0][34:0] i_prod_reg;
    seg_t            i_mode_reg [3];
    logic            j_valid_reg;
    ledcc_pkg::rgb_t j_c_reg;

    logic [7:0] gamma_rg_mem [256];
    logic [7:0] gamma_b_mem  [256];
    ledcc_pkg::rgb_t fifo_mem [ledcc_pkg::FIFO_DEPTH];

    // Saturation front end: extremes, HSL numerators and divisors.
    ledcc_pkg::rgb_t g_c;
    logic [7:0]  mx, mn, dl;
    logic [8:0]  sm, den;
    logic [10:0] d6, num;

    assign g_c = gamma_on ? c_gq_reg : c_c_reg;

    always_comb
    begin
        mx = d_c_reg[0];
        mn = d_c_reg[0];
        if (d_c_reg[1] > mx) mx = d_c_reg[1];
        if (d_c_reg[2] > mx) mx = d_c_reg[2];
        if (d_c_reg[1] < mn) mn = d_c_reg[1];
        if (d_c_reg[2] < mn) mn = d_c_reg[2];
        dl  = mx - mn;
        sm  = 9'(mx) + 9'(mn);
        den = (sm < 9'd255) ? sm : 9'(9'd510 - sm);
        d6  = 11'(dl) * 11'd6;
        if (mx == d_c_reg[0])
        begin
            if (d_c_reg[1] >= d_c_reg[2])
                num = 11'(d_c_reg[1] - d_c_reg[2]);
            else
                num = d6 - 11'(d_c_reg[2]) + 11'(d_c_reg[1]);
        end
        else if (mx == d_c_reg[1])
        begin
            num = 11'(d_c_reg[2]) + (11'(dl) << 1) - 11'(d_c_reg[0]);
        end
        else
        begin
            num = 11'(d_c_reg[0]) + (11'(dl) << 2) - 11'(d_c_reg[1]);
        end
    end

    logic [QW-1:0] s_quot, h_quot;

    ledcc_div u_ledcc_div_sat (
        .clk     (clk),
        .rem_in  (ledcc_pkg::DIV_W'(e_dl_reg[7:1])),
        .div_in  (ledcc_pkg::DIV_W'(e_den_reg)),
        .bits_in ({e_dl_reg[0], {(QW-1){1'b0}}}),
        .quot    (s_quot)
    );

    ledcc_div u_ledcc_div_hue (
        .clk     (clk),
        .rem_in  (ledcc_pkg::DIV_W'(e_num_reg[10:1])),
        .div_in  (ledcc_pkg::DIV_W'(e_d6_reg)),
        .bits_in ({e_num_reg[0], {(QW-1){1'b0}}}),
        .quot    (h_quot)
    );

    // Lightness as sum * 32768 / 255 through a reciprocal with one correction.
    side_t       side_in;
    logic [15:0] ly;
    logic [23:0] ly257;
    logic [7:0]  lq0;
    logic [16:0] lrem;
    logic [8:0]  lq;

    always_comb
    begin
        ly    = {e_sm_reg, 7'b0};
        ly257 = (24'(ly) << 8) + 24'(ly);
        lq0   = ly257[23:16];
        lrem  = 17'(ly) - (17'(lq0) << 8) + 17'(lq0);
        lq    = 9'(lq0) + 9'(lrem >= 17'd255);
        side_in.sat_on = e_sat_on_reg;
        side_in.c      = e_c_reg;
        side_in.dnz    = (e_dl_reg != '0);
        side_in.sm     = e_sm_reg;
        side_in.l      = 17'(ly) + 17'(lq);
    end

    // Saturation gain and the HSL to RGB segment selection.
    logic [33:0] sat_sh, ls_prod;
    logic [16:0] sn;
    logic [17:0] hq, hp, hl2, hq_fix;
    logic [2:0][15:0] ht;
    logic [18:0] t6, t6_fall;
    logic [2:0][16:0] fac;
    seg_t        mode [3];
    logic [17:0] span;

    always_comb
    begin
        sat_sh  = f_prod_reg >> GAIN_FRAC_BITS;
        sn      = (sat_sh > 34'd65536) ? 17'h10000 : sat_sh[16:0];
        ls_prod = 34'(f_side_reg.l) * 34'(sn);
    end

    always_comb
    begin
        if (g_side_reg.l < 17'd32768)
            hq = 18'(g_side_reg.l) + 18'(g_ls_reg);
        else
            hq = 18'(g_side_reg.l) + 18'(g_sn_reg) - 18'(g_ls_reg);
        hl2    = {g_side_reg.l, 1'b0};
        hp     = (hl2 >= hq) ? (hl2 - hq) : '0;
        hq_fix = (hq < hp) ? hp : hq;
        ht[0]  = g_h_reg + 16'd21845;
        ht[1]  = g_h_reg;
        ht[2]  = g_h_reg - 16'd21845;
        t6      = '0;
        t6_fall = '0;
        for (int k = 0; k < 3; k++)
        begin
            t6      = 19'(ht[k]) * 19'd6;
            t6_fall = 19'd262144 - t6;
            if (ht[k] < 16'd10923)
            begin
                mode[k] = SEG_RISE;
                fac[k]  = t6[16:0];
            end
            else if (ht[k] < 16'd32768)
            begin
                mode[k] = SEG_HIGH;
                fac[k]  = '0;
            end
            else if (ht[k] < 16'd43691)
            begin
                mode[k] = SEG_FALL;
                fac[k]  = t6_fall[16:0];
            end
            else
            begin
                mode[k] = SEG_LOW;
                fac[k]  = '0;
            end
        end
        span = hh_q_reg - hh_p_reg;
    end

    // Back to 8-bit channels and final selection.
    ledcc_pkg::rgb_t result;
    logic [18:0] hv;
    logic [26:0] hw;
    logic [7:0]  gray;

    always_comb
    begin
        gray = 8'((10'(i_side_reg.sm) + 10'd1) >> 1);
        hv   = '0;
        hw   = '0;
        for (int k = 0; k < 3; k++)
        begin
            case (i_mode_reg[k])
                SEG_RISE, SEG_FALL: hv = 19'(i_p_reg) + i_prod_reg[k][34:16];
                SEG_HIGH:           hv = 19'(i_q_reg);
                default:            hv = 19'(i_p_reg);
            endcase
            hw = (27'(hv) << 8) - 27'(hv) + 27'd32768;
            if (!i_side_reg.sat_on)
                result[k] = i_side_reg.c[k];
            else if (i_gray_reg)
                result[k] = gray;
            else
                result[k] = (hw[26:16] > 11'd255) ? 8'hFF : hw[23:16];
        end
    end

    always_comb
    begin
        credit_next = credit_reg + ledcc_pkg::CREDIT_W'(in_pixel)
                    - ledcc_pkg::CREDIT_W'(out_pop);
        fill_next   = fill_reg + ledcc_pkg::CREDIT_W'(j_valid_reg)
                    - ledcc_pkg::CREDIT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            side_valid_reg <= '0;
            f_valid_reg    <= 1'b0;
            g_valid_reg    <= 1'b0;
            hh_valid_reg   <= 1'b0;
            i_valid_reg    <= 1'b0;
            j_valid_reg    <= 1'b0;
            credit_reg     <= '0;
            fill_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            a_valid_reg    <= in_accept;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg && (b_req_reg == ledcc_pkg::REQ_PIXEL);
            d_valid_reg    <= c_valid_reg;
            e_valid_reg    <= d_valid_reg;
            side_valid_reg <= {side_valid_reg[ST-2:0], e_valid_reg};
            f_valid_reg    <= side_valid_reg[ST-1];
            g_valid_reg    <= f_valid_reg;
            hh_valid_reg   <= g_valid_reg;
            i_valid_reg    <= hh_valid_reg;
            j_valid_reg    <= i_valid_reg;
            credit_reg     <= credit_next;
            fill_reg       <= fill_next;
            if (j_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_req_reg <= req_type;
        a_c_reg   <= {blue_in, green_in, red_in};
        a_idx_reg <= table_index;
        a_val_reg <= table_value;

        b_req_reg <= a_req_reg;
        b_idx_reg <= a_idx_reg;
        b_val_reg <= a_val_reg;
        for (int k = 0; k < 3; k++)
        begin
            b_c_reg[k] <= white_on ? gain_apply(a_c_reg[k], white_gain[k]) : a_c_reg[k];
        end

        c_c_reg <= b_c_reg;

        for (int k = 0; k < 3; k++)
        begin
            d_c_reg[k] <= bright_on ? gain_apply(g_c[k], bright_gain_reg) : g_c[k];
        end

        e_c_reg      <= d_c_reg;
        e_sat_on_reg <= sat_on;
        e_dl_reg     <= dl;
        e_sm_reg     <= sm;
        e_den_reg    <= den;
        e_d6_reg     <= d6;
        e_num_reg    <= num;

        side_reg[0] <= side_in;
        for (int s = 1; s < ST; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end

        f_side_reg <= side_reg[ST-1];
        f_prod_reg <= 34'(side_reg[ST-1].dnz ? s_quot : '0) * 34'(sat_gain_reg);
        f_h_reg    <= side_reg[ST-1].dnz ? h_quot[15:0] : '0;

        g_side_reg <= f_side_reg;
        g_h_reg    <= f_h_reg;
        g_sn_reg   <= sn;
        g_gray_reg <= (sn < 17'd7);
        g_ls_reg   <= ls_prod[32:16];

        hh_side_reg <= g_side_reg;
        hh_gray_reg <= g_gray_reg;
        hh_p_reg    <= hp;
        hh_q_reg    <= hq_fix;
        hh_fac_reg  <= fac;
        for (int k = 0; k < 3; k++)
        begin
            hh_mode_reg[k] <= mode[k];
        end

        i_side_reg <= hh_side_reg;
        i_gray_reg <= hh_gray_reg;
        i_p_reg    <= hh_p_reg;
        i_q_reg    <= hh_q_reg;
        for (int k = 0; k < 3; k++)
        begin
            i_prod_reg[k] <= 35'(span) * 35'(hh_fac_reg[k]);
            i_mode_reg[k] <= hh_mode_reg[k];
        end

        j_c_reg <= result;

        if (j_valid_reg)
            fifo_mem[wr_ptr_reg] <= j_c_reg;
    end

    // Gamma table, duplicated so that three channels are looked up per cycle.
    always_ff @(posedge clk)
    begin
        if (b_valid_reg && (b_req_reg == ledcc_pkg::REQ_TABLE))
        begin
            gamma_rg_mem[b_idx_reg] <= b_val_reg;
            gamma_b_mem[b_idx_reg]  <= b_val_reg;
        end
        c_gq_reg[0] <= gamma_rg_mem[b_c_reg[0]];
        c_gq_reg[1] <= gamma_rg_mem[b_c_reg[1]];
        c_gq_reg[2] <= gamma_b_mem[b_c_reg[2]];
    end

    assign red_out   = fifo_mem[rd_ptr_reg][0];
    assign green_out = fifo_mem[rd_ptr_reg][1];
    assign blue_out  = fifo_mem[rd_ptr_reg][2];

endmodule

// ===== design/ledcc_checker.sv =====
// Port-level checks for the LED pixel color correction block and its bind.
module ledcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out
);

    // A result waiting to be taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out) && $stable(green_out)
                                   && $stable(blue_out))
        else $error("output payload changed while stalled");

    // Nothing is offered while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // The input is open while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !in_stall)
        else $error("input stalled during reset");

endmodule

bind led_pixel_color_correction ledcc_checker u_ledcc_checker (.*);

// ===== test/tb_led_pixel_color_correction.sv =====
// Self-checking testbench for the LED pixel color correction pipeline.
module tb_led_pixel_color_correction;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = ledcc_pkg::GAIN_FRAC_BITS_DEFAULT;
    localparam longint unsigned UNITY = 64'd1 << FRAC;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES = 200;
    localparam logic [ledcc_pkg::CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [ledcc_pkg::CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam bit [4:0] ON_MASTER = 5'd1 << ledcc_pkg::EN_MASTER;
    localparam bit [4:0] ON_WHITE  = 5'd1 << ledcc_pkg::EN_WHITE;
    localparam bit [4:0] ON_GAMMA  = 5'd1 << ledcc_pkg::EN_GAMMA;
    localparam bit [4:0] ON_BRIGHT = 5'd1 << ledcc_pkg::EN_BRIGHTNESS;
    localparam bit [4:0] ON_SAT    = 5'd1 << ledcc_pkg::EN_SATURATION;
    localparam bit [4:0] ON_ALL    = ON_MASTER | ON_WHITE | ON_GAMMA | ON_BRIGHT | ON_SAT;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct {
        bit [4:0] enables;
        bit       req;
        bit [7:0] red;
        bit [7:0] green;
        bit [7:0] blue;
        bit [7:0] index;
        bit [7:0] value;
        bit       typed;
        pixel_t   result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = ledcc_pkg::REQ_PIXEL;
    logic [7:0] red_in = '0;
    logic [7:0] green_in = '0;
    logic [7:0] blue_in = '0;
    logic [7:0] table_index = '0;
    logic [7:0] table_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ledcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ledcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    bit [4:0] stage_on;
    longint unsigned white_gain [3];
    longint unsigned bright_gain;
    longint unsigned sat_gain;
    bit [7:0] gamma_lut [256];

    pixel_t expected_pixels [$];
    int mismatches = 0;
    int cycles = 0;
    bit sender_quiet = 1'b0;
    bit receiver_quiet = 1'b0;
    bit hold_request = 1'b0;

    led_pixel_color_correction dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .red_in(red_in),
        .green_in(green_in),
        .blue_in(blue_in),
        .table_index(table_index),
        .table_value(table_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red_out(red_out),
        .green_out(green_out),
        .blue_out(blue_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_led_pixel_color_correction failed");
            $finish;
        end
    end

    function automatic longint unsigned scale_channel(longint unsigned c, longint unsigned g);
        longint unsigned p;
        p = (c * g + (UNITY >> 1)) >> FRAC;
        return (p > 255) ? 255 : p;
    endfunction

    function automatic logic [7:0] hue_level(longint unsigned p, longint unsigned q,
                                             longint unsigned t);
        longint unsigned v;
        if (t < 10923)
            v = p + (((q - p) * (6 * t)) >> 16);
        else if (t < 32768)
            v = q;
        else if (t < 43691)
            v = p + (((q - p) * (262144 - 6 * t)) >> 16);
        else
            v = p;
        v = (v * 255 + 32768) >> 16;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic pixel_t resaturate(longint unsigned r, longint unsigned g,
                                          longint unsigned b);
        longint unsigned mx, mn, d, sum, s, h, l, n, den, ls, q, p, gray;
        pixel_t o;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        l = (sum * 32768) / 255;
        s = 0;
        h = 0;
        if (d != 0)
        begin
            den = (sum < 255) ? sum : 510 - sum;
            s = (d * 65536) / den;
            if (mx == r)
                n = (g >= b) ? g - b : 6 * d - (b - g);
            else if (mx == g)
                n = b + 2 * d - r;
            else
                n = r + 4 * d - g;
            h = ((n * 65536) / (6 * d)) & 64'hFFFF;
        end
        s = (s * sat_gain) >> FRAC;
        if (s > 65536) s = 65536;
        if (s < 7)
        begin
            gray = (sum + 1) >> 1;
            o.red = gray[7:0];
            o.green = gray[7:0];
            o.blue = gray[7:0];
            return o;
        end
        ls = (l * s) >> 16;
        q = (l < 32768) ? l + ls : l + s - ls;
        p = (2 * l >= q) ? 2 * l - q : 0;
        if (q < p) q = p;
        o.red = hue_level(p, q, (h + 21845) & 64'hFFFF);
        o.green = hue_level(p, q, h);
        o.blue = hue_level(p, q, (h + 65536 - 21845) & 64'hFFFF);
        return o;
    endfunction

    function automatic pixel_t correct_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        longint unsigned c [3];
        pixel_t o;
        c[0] = 64'(r);
        c[1] = 64'(g);
        c[2] = 64'(b);
        if (stage_on[ledcc_pkg::EN_MASTER])
        begin
            if (stage_on[ledcc_pkg::EN_WHITE])
                for (int i = 0; i < 3; i++) c[i] = scale_channel(c[i], white_gain[i]);
            if (stage_on[ledcc_pkg::EN_GAMMA])
                for (int i = 0; i < 3; i++) c[i] = 64'(gamma_lut[c[i][7:0]]);
            if (stage_on[ledcc_pkg::EN_BRIGHTNESS] && bright_gain != UNITY)
                for (int i = 0; i < 3; i++) c[i] = scale_channel(c[i], bright_gain);
            if (stage_on[ledcc_pkg::EN_SATURATION] && sat_gain != UNITY)
                return resaturate(c[0], c[1], c[2]);
        end
        o.red = c[0][7:0];
        o.green = c[1][7:0];
        o.blue = c[2][7:0];
        return o;
    endfunction

    task automatic write_reg(logic [ledcc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ledcc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            ledcc_pkg::REG_STAGE_ENABLES:   stage_on = data[4:0];
            ledcc_pkg::REG_RED_GAIN:        white_gain[0] = 64'(data);
            ledcc_pkg::REG_GREEN_GAIN:      white_gain[1] = 64'(data);
            ledcc_pkg::REG_BLUE_GAIN:       white_gain[2] = 64'(data);
            ledcc_pkg::REG_BRIGHTNESS_GAIN: bright_gain = 64'(data);
            ledcc_pkg::REG_SATURATION_GAIN: sat_gain = 64'(data);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(bit req, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] ti, logic [7:0] tv, bit typed, pixel_t result);
        int gap;
        gap = sender_quiet ? 0 : int'($urandom_range(0, 7));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        table_index <= ti;
        table_value <= tv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (req == ledcc_pkg::REQ_TABLE)
            gamma_lut[ti] = tv;
        else
            expected_pixels.push_back(typed ? result : correct_pixel(r, g, b));
    endtask

    task automatic send_random();
        bit req;
        req = ($urandom_range(0, 99) < 15) ? ledcc_pkg::REQ_TABLE : ledcc_pkg::REQ_PIXEL;
        send_item(req, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'b0, '0);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return UNITY[15:0];
            3: return 16'($urandom_range(1024, 8192));
            4: return 16'($urandom_range(0, 2048));
            default: return 16'($urandom);
        endcase
    endfunction

    always
    begin
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            n = receiver_quiet ? 0 : int'($urandom_range(0, 7));
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %h", red_out, green_out, blue_out);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (red_out !== want.red || green_out !== want.green
                    || blue_out !== want.blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h, got %h %h %h",
                                 want.red, want.green, want.blue,
                                 red_out, green_out, blue_out);
                end
            end
        end
    end

    stim_row_t directed_rows [] = '{
        '{5'd0, ledcc_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'h00, 8'h00, 8'h00}},
        '{5'd0, ledcc_pkg::REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{8'hFF, 8'hFF, 8'hFF}},
        '{5'd0, ledcc_pkg::REQ_PIXEL, 8'hA5, 8'h5A, 8'h3C, 8'h00, 8'h00, 1'b1,
          '{8'hA5, 8'h5A, 8'h3C}},
        '{ON_MASTER, ledcc_pkg::REQ_PIXEL, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 1'b1,
          '{8'h12, 8'h34, 8'h56}},
        '{ON_MASTER | ON_GAMMA, ledcc_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h10, 8'h00, 8'h00,
          1'b1, '{8'hFF, 8'h00, 8'hEF}},
        '{ON_MASTER | ON_WHITE, ledcc_pkg::REQ_PIXEL, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00,
          1'b1, '{8'd16, 8'd0, 8'd2}},
        '{ON_MASTER | ON_WHITE, ledcc_pkg::REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
          1'b1, '{8'hFF, 8'h00, 8'hFF}},
        '{ON_MASTER | ON_WHITE, ledcc_pkg::REQ_TABLE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77,
          1'b0, '0},
        '{ON_MASTER | ON_GAMMA, ledcc_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          1'b1, '{8'h77, 8'h77, 8'h77}},
        '{ON_MASTER | ON_BRIGHT, ledcc_pkg::REQ_PIXEL, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00,
          1'b1, '{8'd128, 8'd1, 8'd0}},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd200, 8'd50, 8'd50, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd50, 8'd200, 8'd50, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd50, 8'd50, 8'd200, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd128, 8'd128, 8'd128, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd255, 8'd0, 8'd0, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd10, 8'd250, 8'd250, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_MASTER | ON_SAT, ledcc_pkg::REQ_PIXEL, 8'd90, 8'd30, 8'd200, 8'h00, 8'h00,
          1'b0, '0},
        '{ON_ALL, ledcc_pkg::REQ_PIXEL, 8'd37, 8'd180, 8'd99, 8'h00, 8'h00, 1'b0, '0},
        '{ON_ALL, ledcc_pkg::REQ_PIXEL, 8'd255, 8'd128, 8'd0, 8'h00, 8'h00, 1'b0, '0}
    };

    initial
    begin
        bit [4:0] enables_now;
        stage_on = '0;
        white_gain = '{UNITY, UNITY, UNITY};
        bright_gain = UNITY;
        sat_gain = UNITY;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through rows run on reset values; the table is then loaded inverted.
        for (int i = 0; i < 3; i++)
            send_item(directed_rows[i].req, directed_rows[i].red, directed_rows[i].green,
                      directed_rows[i].blue, directed_rows[i].index,
                      directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].result);
        for (int i = 0; i < 256; i++)
            send_item(ledcc_pkg::REQ_TABLE, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'(i), 8'(255 - i), 1'b0, '0);
        in_valid <= 1'b0;
        wait_idle();
        write_reg(ledcc_pkg::REG_RED_GAIN, 16'hFFFF);
        write_reg(ledcc_pkg::REG_GREEN_GAIN, 16'h0000);
        write_reg(ledcc_pkg::REG_BLUE_GAIN, 16'd6144);
        write_reg(ledcc_pkg::REG_BRIGHTNESS_GAIN, 16'd2048);
        write_reg(ledcc_pkg::REG_SATURATION_GAIN, 16'd8192);
        write_reg(REG_UNUSED_6, 16'hFFFF);
        write_reg(REG_UNUSED_7, 16'h1234);
        write_reg(ledcc_pkg::REG_STAGE_ENABLES, 16'hFFE0);
        cfg_valid <= 1'b0;
        enables_now = '0;
        for (int i = 3; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].enables != enables_now)
            begin
                in_valid <= 1'b0;
                wait_idle();
                write_reg(ledcc_pkg::REG_STAGE_ENABLES, {11'h7FF, directed_rows[i].enables});
                cfg_valid <= 1'b0;
                enables_now = directed_rows[i].enables;
            end
            send_item(directed_rows[i].req, directed_rows[i].red, directed_rows[i].green,
                      directed_rows[i].blue, directed_rows[i].index,
                      directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].result);
        end

        for (int phase = 0; phase < 14; phase++)
        begin
            in_valid <= 1'b0;
            wait_idle();
            write_reg(ledcc_pkg::REG_RED_GAIN, pick_gain());
            write_reg(ledcc_pkg::REG_GREEN_GAIN, pick_gain());
            write_reg(ledcc_pkg::REG_BLUE_GAIN, pick_gain());
            write_reg(ledcc_pkg::REG_BRIGHTNESS_GAIN, pick_gain());
            write_reg(ledcc_pkg::REG_SATURATION_GAIN, pick_gain());
            if (phase == 0)
                write_reg(ledcc_pkg::REG_STAGE_ENABLES, 16'(ON_ALL));
            else if (phase % 5 == 4)
                write_reg(ledcc_pkg::REG_STAGE_ENABLES, 16'($urandom));
            else
                write_reg(ledcc_pkg::REG_STAGE_ENABLES, 16'($urandom | ON_MASTER));
            cfg_valid <= 1'b0;
            sender_quiet = (phase % 4 == 1) || (phase == 3);
            receiver_quiet = (phase % 4 == 1) || (phase == 6);
            if (phase == 3)
                hold_request = 1'b1;
            for (int k = 0; k < 55; k++)
            begin
                if (phase == 5 && k == 40)
                begin
                    in_valid <= 1'b0;
                    while (expected_pixels.size() != 0) @(posedge clk);
                end
                send_random();
            end
        end
        in_valid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_led_pixel_color_correction passed");
        else
            $display("tb_led_pixel_color_correction failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ledcc_pkg.sv
design/ledcc_div.sv
design/led_pixel_color_correction.sv
design/ledcc_checker.sv
test/tb_led_pixel_color_correction.sv
